[sv/hill_cipher_2x2_stream_macros.svh]
// Assertion macros for the checker file of the Hill cipher stream block.
`ifndef HILL_CIPHER_2X2_STREAM_MACROS_SVH
`define HILL_CIPHER_2X2_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HC2_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hc2 assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HC2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hc2 assertion failed");

`endif

[sv/hc2_pkg.sv]
// Types, constants and mod-26 helpers for the 2x2 Hill cipher stream block.
package hc2_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned CharW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned SumW     = 11;
  localparam int unsigned AlphaLen = 26;
  // floor(x * Recip26 / 2^16) == floor(x / 26) for all x < 2048
  localparam int unsigned Recip26  = 2521;
  localparam int unsigned SettleCycles = 2;

  localparam logic [CharW-1:0] AsciiA = 8'h61;
  localparam logic [CharW-1:0] AsciiZ = 8'h7a;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDirection   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyTopLeft  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyTopRight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyBotLeft  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyBotRight = 3'd4;

  // Effective mixing matrix plus the bad-key flag
  typedef struct packed {
    logic [LetterW-1:0] m00;
    logic [LetterW-1:0] m01;
    logic [LetterW-1:0] m10;
    logic [LetterW-1:0] m11;
    logic               err;
  } key_matrix_t;

  // Letter pair on its way to the mixer
  typedef struct packed {
    logic [LetterW-1:0] p0;
    logic [LetterW-1:0] p1;
  } pair_t;

  // Remainder mod 26 of an 11-bit value by reciprocal multiply
  function automatic logic [LetterW-1:0] mod26(input logic [SumW-1:0] x);
    logic [22:0]     prod;
    logic [6:0]      quo;
    logic [SumW-1:0] qm;
    prod = 23'(x) * 23'(Recip26);
    quo  = prod[22:16];
    qm   = SumW'(quo) * SumW'(AlphaLen);
    return LetterW'(x - qm);
  endfunction

  // Fold a 5-bit key entry into 0..25
  function automatic logic [LetterW-1:0] fold26(input logic [LetterW-1:0] x);
    return (x >= LetterW'(AlphaLen)) ? LetterW'(x - LetterW'(AlphaLen)) : x;
  endfunction

  // Inverse of a residue mod 26, zero for non-units
  function automatic logic [LetterW-1:0] unit_inverse(input logic [LetterW-1:0] x);
    logic [LetterW-1:0] r;
    case (x)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/hill_cipher_2x2_stream.sv]
// Top level of the streaming 2x2 Hill cipher over the letters a to z.
//
// Input channel (in_*): one text byte per word, with in_end_of_text on the
// last byte. Bytes outside 'a'..'z' are dropped; letters are paired in order
// and a lone trailing letter is paired with 'a' at end of text.
// Output channel (out_*): two words per pair, out_last_of_run on the second.
// Decrypting with a key whose determinant has no inverse mod 26 gives
// out_char = 0 and out_key_error = 1 on both words.
// Config channel (cfg_*): index 0 direction, 1..4 key entries row by row.
// Write it only while the block is idle; in_ready drops during the write and
// stays low after it while the inverse-key pipeline reloads.
// Throughput: one input word per cycle while in_ready is high; the output takes
// one word per cycle when out_ready is high, so a pair completed on every input
// (end-of-text flushes) stalls the input. A completing input word passes through
// the pair register, then the result buffer, before its first result shows.
// Reset: clears the key, the direction and any pending letter; in_ready stays
// low after reset while the inverse-key pipeline reloads. A stalled receiver
// holds the result buffer and backs up through the pair register to in_ready.
module hill_cipher_2x2_stream (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hc2_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [hc2_pkg::LetterW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hc2_pkg::CharW-1:0]   in_text_byte,
  input  logic                        in_end_of_text,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hc2_pkg::CharW-1:0]   out_char,
  output logic                        out_key_error,
  output logic                        out_last_of_run
);

  hc2_pkg::key_matrix_t key;
  hc2_pkg::pair_t       pair;
  logic                 settling;
  logic                 pair_valid;
  logic                 pair_ready;

  hc2_key u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key),
    .settling  (settling)
  );

  hc2_pair u_pair (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (settling),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .pair_valid     (pair_valid),
    .pair_ready     (pair_ready),
    .pair           (pair)
  );

  hc2_mix u_mix (
    .clk             (clk),
    .rst_n           (rst_n),
    .pair_valid      (pair_valid),
    .pair_ready      (pair_ready),
    .pair            (pair),
    .key             (key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_key_error   (out_key_error),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[sv/hc2_key.sv]
// Configuration registers and the two-stage key matrix / inverse pipeline.
module hc2_key (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hc2_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hc2_pkg::LetterW-1:0]   cfg_data,
  output hc2_pkg::key_matrix_t          key,
  output logic                          settling
);

  logic                         dir_r;
  logic [hc2_pkg::LetterW-1:0]  ktl_r, ktr_r, kbl_r, kbr_r;
  logic [1:0]                   settle_r, settle_nxt;

  // stage 1: folded entries, determinant, base matrix
  logic [hc2_pkg::LetterW-1:0]  a, b, c, d;
  logic [hc2_pkg::LetterW-1:0]  det_nxt, det_r;
  hc2_pkg::key_matrix_t         base_nxt, base_r;
  logic                         s1_dir_r;

  // stage 2: scaled matrix
  logic [hc2_pkg::LetterW-1:0]  inv;
  hc2_pkg::key_matrix_t         key_nxt, key_r;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
      ktl_r <= '0;
      ktr_r <= '0;
      kbl_r <= '0;
      kbr_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hc2_pkg::CfgDirection:   dir_r <= cfg_data[0];
        hc2_pkg::CfgKeyTopLeft:  ktl_r <= cfg_data;
        hc2_pkg::CfgKeyTopRight: ktr_r <= cfg_data;
        hc2_pkg::CfgKeyBotLeft:  kbl_r <= cfg_data;
        hc2_pkg::CfgKeyBotRight: kbr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off input until the matrix pipeline has caught up with a write
  always_comb begin
    if (cfg_valid) begin
      settle_nxt = 2'(hc2_pkg::SettleCycles);
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'(hc2_pkg::SettleCycles);
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign settling = cfg_valid | (settle_r != 2'd0);

  // stage 1: det = a*d - b*c mod 26; base is the key or its adjugate
  always_comb begin
    a = hc2_pkg::fold26(ktl_r);
    b = hc2_pkg::fold26(ktr_r);
    c = hc2_pkg::fold26(kbl_r);
    d = hc2_pkg::fold26(kbr_r);
    det_nxt = hc2_pkg::mod26(hc2_pkg::SumW'(a) * hc2_pkg::SumW'(d)
              + hc2_pkg::SumW'(hc2_pkg::AlphaLen * hc2_pkg::AlphaLen)
              - hc2_pkg::SumW'(b) * hc2_pkg::SumW'(c));
    base_nxt.err = 1'b0;
    if (dir_r) begin
      base_nxt.m00 = d;
      base_nxt.m01 = (b == '0) ? '0 : 5'(hc2_pkg::LetterW'(hc2_pkg::AlphaLen) - b);
      base_nxt.m10 = (c == '0) ? '0 : 5'(hc2_pkg::LetterW'(hc2_pkg::AlphaLen) - c);
      base_nxt.m11 = a;
    end else begin
      base_nxt.m00 = a;
      base_nxt.m01 = b;
      base_nxt.m10 = c;
      base_nxt.m11 = d;
    end
  end

  always_ff @(posedge clk) begin
    det_r    <= det_nxt;
    base_r   <= base_nxt;
    s1_dir_r <= dir_r;
  end

  // stage 2: when decrypting, scale the adjugate by the determinant's inverse; else pass the key
  always_comb begin
    inv = hc2_pkg::unit_inverse(det_r);
    if (s1_dir_r) begin
      key_nxt.m00 = hc2_pkg::mod26(hc2_pkg::SumW'(base_r.m00) * hc2_pkg::SumW'(inv));
      key_nxt.m01 = hc2_pkg::mod26(hc2_pkg::SumW'(base_r.m01) * hc2_pkg::SumW'(inv));
      key_nxt.m10 = hc2_pkg::mod26(hc2_pkg::SumW'(base_r.m10) * hc2_pkg::SumW'(inv));
      key_nxt.m11 = hc2_pkg::mod26(hc2_pkg::SumW'(base_r.m11) * hc2_pkg::SumW'(inv));
      key_nxt.err = (inv == '0);
    end else begin
      key_nxt = base_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

[sv/hc2_pair.sv]
// Input stage: letter filter, pending-letter register and pair register.
module hc2_pair (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hc2_pkg::CharW-1:0]   in_text_byte,
  input  logic                        in_end_of_text,
  output logic                        pair_valid,
  input  logic                        pair_ready,
  output hc2_pkg::pair_t              pair
);

  logic                         held_valid_r, held_valid_nxt;
  logic [hc2_pkg::LetterW-1:0]  held_letter_r, held_letter_nxt;
  logic                         pair_valid_r, pair_valid_nxt;
  hc2_pkg::pair_t               pair_r, pair_nxt;
  logic                         accept;
  logic                         is_letter;
  logic                         emit;
  logic [hc2_pkg::LetterW-1:0]  idx;

  assign in_ready = !hold && (!pair_valid_r || pair_ready);
  assign accept   = in_valid && in_ready;

  // pairing decision for the accepted word
  always_comb begin
    is_letter       = in_text_byte inside {[hc2_pkg::AsciiA:hc2_pkg::AsciiZ]};
    idx             = hc2_pkg::LetterW'(in_text_byte - hc2_pkg::AsciiA);
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    emit            = 1'b0;
    pair_nxt        = pair_r;
    if (accept) begin
      if (is_letter && held_valid_r) begin
        emit            = 1'b1;
        pair_nxt.p0     = held_letter_r;
        pair_nxt.p1     = idx;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end else if (is_letter && in_end_of_text) begin
        // odd trailing letter, padded with 'a'
        emit            = 1'b1;
        pair_nxt.p0     = idx;
        pair_nxt.p1     = '0;
      end else if (is_letter) begin
        held_valid_nxt  = 1'b1;
        held_letter_nxt = idx;
      end else if (in_end_of_text && held_valid_r) begin
        emit            = 1'b1;
        pair_nxt.p0     = held_letter_r;
        pair_nxt.p1     = '0;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end
    end
    if (emit) begin
      pair_valid_nxt = 1'b1;
    end else if (pair_ready) begin
      pair_valid_nxt = 1'b0;
    end else begin
      pair_valid_nxt = pair_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
      pair_valid_r  <= 1'b0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_letter_r <= held_letter_nxt;
      pair_valid_r  <= pair_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

  assign pair_valid = pair_valid_r;
  assign pair       = pair_r;

endmodule

[sv/hc2_mix.sv]
// Matrix product mod 26 and the two-word result buffer feeding the output.
module hc2_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pair_valid,
  output logic                        pair_ready,
  input  hc2_pkg::pair_t              pair,
  input  hc2_pkg::key_matrix_t        key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hc2_pkg::CharW-1:0]   out_char,
  output logic                        out_key_error,
  output logic                        out_last_of_run
);

  localparam logic [1:0] PairWords = 2'd2;

  logic [1:0]                   left_r, left_nxt;
  logic [hc2_pkg::CharW-1:0]    word0_r, word1_r;
  logic [hc2_pkg::CharW-1:0]    word0_nxt, word1_nxt;
  logic                         err_r;
  logic [hc2_pkg::SumW-1:0]     v0, v1;
  logic                         take_pair;
  logic                         take_word;

  // a new pair may enter when the buffer is empty or as its last word leaves
  assign out_valid  = (left_r != 2'd0);
  assign take_word  = out_valid && out_ready;
  assign pair_ready = (left_r == 2'd0) || ((left_r == 2'd1) && out_ready);
  assign take_pair  = pair_valid && pair_ready;

  // c = M * p mod 26
  always_comb begin
    v0 = hc2_pkg::SumW'(key.m00) * hc2_pkg::SumW'(pair.p0)
       + hc2_pkg::SumW'(key.m01) * hc2_pkg::SumW'(pair.p1);
    v1 = hc2_pkg::SumW'(key.m10) * hc2_pkg::SumW'(pair.p0)
       + hc2_pkg::SumW'(key.m11) * hc2_pkg::SumW'(pair.p1);
    word0_nxt = key.err ? '0 : hc2_pkg::AsciiA + hc2_pkg::CharW'(hc2_pkg::mod26(v0));
    word1_nxt = key.err ? '0 : hc2_pkg::AsciiA + hc2_pkg::CharW'(hc2_pkg::mod26(v1));
  end

  // words left in the buffer
  always_comb begin
    if (take_pair) begin
      left_nxt = PairWords;
    end else if (take_word) begin
      left_nxt = left_r - 2'd1;
    end else begin
      left_nxt = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pair) begin
      word0_r <= word0_nxt;
      word1_r <= word1_nxt;
      err_r   <= key.err;
    end
  end

  assign out_char        = (left_r == PairWords) ? word0_r : word1_r;
  assign out_key_error   = err_r;
  assign out_last_of_run = (left_r == 2'd1);

endmodule

[sv/hc2_check.sv]
// Port-level checker for the Hill cipher stream block, with its bind.
`include "hill_cipher_2x2_stream_macros.svh"

module hc2_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hc2_pkg::CharW-1:0]   out_char,
  input logic                        out_key_error,
  input logic                        out_last_of_run
);

  // a bad-key word carries no letter
  `HC2_ASSERT_IMPL(a_err_char_zero, clk, rst_n, out_valid && out_key_error, out_char == '0)

  // a good word is a lowercase letter
  `HC2_ASSERT_IMPL(a_char_letter, clk, rst_n, out_valid && !out_key_error,
    (out_char >= hc2_pkg::AsciiA) && (out_char <= hc2_pkg::AsciiZ))

  // the second word of a pair follows the first at once, same error flag
  `HC2_ASSERT_NEXT(a_pair_second, clk, rst_n, out_valid && out_ready && !out_last_of_run,
    out_valid && out_last_of_run && $stable(out_key_error))

  // a stalled result word holds
  `HC2_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_char) && $stable(out_last_of_run))

endmodule

bind hill_cipher_2x2_stream hc2_check u_check (.*);

[test/tb_hill_cipher_2x2_stream.sv]
// Self-checking testbench for the 2x2 Hill cipher stream block: directed and random text.
`timescale 1ns / 1ps

module tb_hill_cipher_2x2_stream;

  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SegmentCount = 6;
  localparam int unsigned SegmentBytes = 105;

  // One output word: letter, bad-key flag, second-of-pair flag
  typedef struct {
    logic [hc2_pkg::CharW-1:0] ch;
    logic                      err;
    logic                      last;
  } cipher_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hc2_pkg::CfgIdxW-1:0]   cfg_index;
  logic [hc2_pkg::LetterW-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [hc2_pkg::CharW-1:0]     in_text_byte;
  logic                          in_end_of_text;
  logic                          out_valid;
  logic                          out_ready;
  logic [hc2_pkg::CharW-1:0]     out_char;
  logic                          out_key_error;
  logic                          out_last_of_run;

  // Shadow of the block's registers and pairing state
  logic                          shadow_decrypt;
  logic [hc2_pkg::LetterW-1:0]   shadow_key [4];
  logic [hc2_pkg::LetterW-1:0]   shadow_held_letter;
  logic                          shadow_held_valid;

  cipher_word_t         cipher_words_q[$];
  cipher_word_t         exp_word;
  int                   mismatch_count;
  int unsigned          stall_cycles;
  int unsigned          in_idle_pct;
  int unsigned          out_idle_pct;

  hill_cipher_2x2_stream u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_key_error   (out_key_error),
    .out_last_of_run (out_last_of_run)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Inverse of a residue mod 26 by search; 0 when the residue is not a unit
  function automatic int unsigned det_inverse_mod26(input int unsigned x);
    int unsigned r;
    r = 0;
    for (int unsigned i = 1; i < hc2_pkg::AlphaLen; i++) begin
      if ((x * i) % hc2_pkg::AlphaLen == 1) r = i;
    end
    return r;
  endfunction

  // Cipher one letter pair with the current key and queue both words
  function automatic void push_cipher_pair(input int unsigned p0, input int unsigned p1);
    int unsigned  a, b, c, d, det, dinv, n;
    int unsigned  m00, m01, m10, m11, v0, v1;
    logic         bad;
    cipher_word_t w;
    n = hc2_pkg::AlphaLen;
    a = shadow_key[0] % n;
    b = shadow_key[1] % n;
    c = shadow_key[2] % n;
    d = shadow_key[3] % n;
    m00 = a; m01 = b; m10 = c; m11 = d;
    bad = 1'b0;
    if (shadow_decrypt) begin
      det  = (a * d + n * n - b * c) % n;
      dinv = det_inverse_mod26(det);
      if (dinv == 0) begin
        bad = 1'b1;
      end else begin
        m00 = (d * dinv) % n;
        m01 = (((n - b) % n) * dinv) % n;
        m10 = (((n - c) % n) * dinv) % n;
        m11 = (a * dinv) % n;
      end
    end
    v0 = (m00 * p0 + m01 * p1) % n;
    v1 = (m10 * p0 + m11 * p1) % n;
    w.ch   = bad ? '0 : hc2_pkg::AsciiA + hc2_pkg::CharW'(v0);
    w.err  = bad;
    w.last = 1'b0;
    cipher_words_q.push_back(w);
    w.ch   = bad ? '0 : hc2_pkg::AsciiA + hc2_pkg::CharW'(v1);
    w.last = 1'b1;
    cipher_words_q.push_back(w);
  endfunction

  // Advance the pairing state by one accepted byte
  function automatic void hill_predict_byte(input logic [hc2_pkg::CharW-1:0] b,
                                            input logic eot);
    int unsigned idx;
    if (b >= hc2_pkg::AsciiA && b <= hc2_pkg::AsciiZ) begin
      idx = b - hc2_pkg::AsciiA;
      if (shadow_held_valid) begin
        push_cipher_pair(shadow_held_letter, idx);
        shadow_held_valid  = 1'b0;
        shadow_held_letter = '0;
      end else begin
        shadow_held_letter = hc2_pkg::LetterW'(idx);
        shadow_held_valid  = 1'b1;
      end
    end
    // lone trailing letter gets padded with 'a'
    if (eot && shadow_held_valid) begin
      push_cipher_pair(shadow_held_letter, 0);
      shadow_held_valid  = 1'b0;
      shadow_held_letter = '0;
    end
  endfunction

  function automatic void apply_cipher_reg(input logic [hc2_pkg::CfgIdxW-1:0] idx,
                                           input logic [hc2_pkg::LetterW-1:0] val);
    case (idx)
      hc2_pkg::CfgDirection:   shadow_decrypt = val[0];
      hc2_pkg::CfgKeyTopLeft:  shadow_key[0] = val;
      hc2_pkg::CfgKeyTopRight: shadow_key[1] = val;
      hc2_pkg::CfgKeyBotLeft:  shadow_key[2] = val;
      hc2_pkg::CfgKeyBotRight: shadow_key[3] = val;
      default: ;
    endcase
  endfunction

  // Drop valid and let every expected word drain, plus settle time
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cipher_words_q.size() != 0) @(posedge clk);
    repeat (hc2_pkg::SettleCycles + 2) @(posedge clk);
  endtask

  task automatic write_cipher_reg(input logic [hc2_pkg::CfgIdxW-1:0] idx,
                                  input logic [hc2_pkg::LetterW-1:0] val);
    wait_for_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cipher_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input logic [hc2_pkg::LetterW-1:0] dir,
                          input logic [hc2_pkg::LetterW-1:0] k00,
                          input logic [hc2_pkg::LetterW-1:0] k01,
                          input logic [hc2_pkg::LetterW-1:0] k10,
                          input logic [hc2_pkg::LetterW-1:0] k11);
    write_cipher_reg(hc2_pkg::CfgDirection, dir);
    write_cipher_reg(hc2_pkg::CfgKeyTopLeft, k00);
    write_cipher_reg(hc2_pkg::CfgKeyTopRight, k01);
    write_cipher_reg(hc2_pkg::CfgKeyBotLeft, k10);
    write_cipher_reg(hc2_pkg::CfgKeyBotRight, k11);
  endtask

  // Send one text word; valid stays up after acceptance until the next call
  task automatic send_text_byte(input logic [hc2_pkg::CharW-1:0] b, input logic eot);
    @(negedge clk);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    hill_predict_byte(b, eot);
  endtask

  // Zero key out of reset: every letter maps to 'a'
  task automatic test_reset_state();
    send_text_byte("z", 1'b0);
    send_text_byte("a", 1'b0);
  endtask

  // Byte extremes, dropped bytes and all end-of-text cases
  task automatic test_filter_and_flush();
    load_key(5'd0, 5'd3, 5'd3, 5'd2, 5'd5);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(hc2_pkg::AsciiA, 1'b0);
    send_text_byte(hc2_pkg::AsciiA - 8'd1, 1'b0);
    send_text_byte(hc2_pkg::AsciiZ + 8'd1, 1'b0);
    send_text_byte(hc2_pkg::AsciiZ, 1'b0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte("h", 1'b0);
    send_text_byte("A", 1'b1);       // non-letter flushes the pending letter
    send_text_byte("q", 1'b1);       // lone letter with end of text
    send_text_byte(" ", 1'b1);       // end with nothing pending
    send_text_byte("c", 1'b0);
    send_text_byte("d", 1'b1);       // end on a completing letter
  endtask

  // Decrypt with good, folded and singular keys; unused indexes are ignored
  task automatic test_decrypt_keys();
    load_key(5'd1, 5'd3, 5'd3, 5'd2, 5'd5);
    send_text_byte("m", 1'b0);
    send_text_byte("n", 1'b0);
    for (int i = hc2_pkg::CfgKeyBotRight + 1; i < (1 << hc2_pkg::CfgIdxW); i++) begin
      write_cipher_reg(hc2_pkg::CfgIdxW'(i), 5'd31);
    end
    load_key(5'd31, 5'd29, 5'd26, 5'd31, 5'd27);
    send_text_byte("k", 1'b0);
    send_text_byte("e", 1'b0);
    load_key(5'd1, 5'd2, 5'd4, 5'd6, 5'd8);
    send_text_byte("x", 1'b0);
    send_text_byte("y", 1'b0);
    send_text_byte("w", 1'b1);
    load_key(5'd30, 5'd2, 5'd4, 5'd6, 5'd8);   // even data: encrypt, no error
    send_text_byte("g", 1'b0);
    send_text_byte("o", 1'b1);
  endtask

  // Random keys per segment, mostly letters with some noise and end marks
  task automatic test_random_stream(input int unsigned in_pct, input int unsigned out_pct);
    int unsigned                 sel;
    logic [hc2_pkg::CharW-1:0]   b;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int s = 0; s < SegmentCount; s++) begin
      sel = $urandom_range(9);
      case (sel)
        0: load_key(5'($urandom_range(31)), 5'd0, 5'd0, 5'd0, 5'd0);
        1: load_key(5'($urandom_range(31)), 5'd31, 5'd31, 5'd31, 5'd31);
        2: load_key(5'($urandom_range(31)), 5'd25, 5'd25, 5'd25, 5'd24);
        default: load_key(5'($urandom_range(31)), 5'($urandom_range(31)),
                          5'($urandom_range(31)), 5'($urandom_range(31)),
                          5'($urandom_range(31)));
      endcase
      for (int n = 0; n < SegmentBytes; n++) begin
        if ($urandom_range(99) < 78) begin
          b = hc2_pkg::AsciiA + hc2_pkg::CharW'($urandom_range(hc2_pkg::AlphaLen - 1));
        end else begin
          b = hc2_pkg::CharW'($urandom_range(255));
        end
        send_text_byte(b, ($urandom_range(11) == 0) || (n == SegmentBytes - 1));
      end
    end
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cipher_words_q.size() == 0) begin
        $display("%0t: unexpected word char=%h err=%b last=%b", $time,
                 out_char, out_key_error, out_last_of_run);
        mismatch_count++;
      end else begin
        exp_word = cipher_words_q.pop_front();
        if (out_char !== exp_word.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, exp_word.ch, out_char);
          mismatch_count++;
        end
        if (out_key_error !== exp_word.err) begin
          $display("%0t: out_key_error expected %b actual %b", $time,
                   exp_word.err, out_key_error);
          mismatch_count++;
        end
        if (out_last_of_run !== exp_word.last) begin
          $display("%0t: out_last_of_run expected %b actual %b", $time,
                   exp_word.last, out_last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_text_byte   = '0;
    in_end_of_text = 1'b0;
    out_ready      = 1'b0;
    in_idle_pct    = 31;
    out_idle_pct   = 50;
    shadow_decrypt     = 1'b0;
    shadow_key         = '{default: '0};
    shadow_held_letter = '0;
    shadow_held_valid  = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_filter_and_flush();
    test_decrypt_keys();
    test_random_stream(31, 50);
    test_random_stream(50, 31);
    test_random_stream(0, 0);

    wait_for_quiet();
    repeat (hc2_pkg::SettleCycles + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
